[rtl/crbc_pkg.sv]
package crbc_pkg;

  // Fixed RAM geometry: one 8 KiB RAM bank
  localparam int unsigned RAM_BYTES = 8192;
  localparam int unsigned RAM_AW    = $clog2(RAM_BYTES);

  localparam int unsigned BANK_W    = 5;
  localparam int unsigned BANK_OFS_W = 14;  // 16 KiB window

  localparam logic [7:0] OPEN_BUS   = 8'hFF;
  localparam logic [3:0] RAM_ON_KEY = 4'hA;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DW    = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROM_SIZE = 1'b0,
    REG_RAM_SIZE = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LOAD  = 2'd2
  } op_t;

  // Where the byte of a read comes from
  typedef enum logic [1:0] {
    SRC_ROM  = 2'd0,
    SRC_RAM  = 2'd1,
    SRC_OPEN = 2'd2
  } rd_src_t;

  typedef struct packed {
    logic    rom_en;
    logic    rom_we;
    logic    ram_en;
    logic    ram_we;
    logic    rd_valid;
    rd_src_t rd_src;
  } mem_req_t;

  function automatic logic [BANK_W-1:0] bank_mask(input logic [3:0] code);
    logic [BANK_W-1:0] m;
    case (code)
      4'd0:    m = 5'h01;
      4'd1:    m = 5'h03;
      4'd2:    m = 5'h07;
      4'd3:    m = 5'h0F;
      default: m = 5'h1F;
    endcase
    return m;
  endfunction

endpackage

[rtl/crbc_ram.sv]
module crbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/crbc_decode.sv]
module crbc_decode #(
  parameter int unsigned ROM_BYTES = 524288
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [crbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [crbc_pkg::CFG_DW-1:0]  cfg_data,
  input  logic                         accept,
  input  logic [1:0]                   operation,
  input  logic [15:0]                  bus_address,
  input  logic [18:0]                  rom_index,
  input  logic [7:0]                   data_in,
  output crbc_pkg::mem_req_t           req,
  output logic [$clog2(ROM_BYTES)-1:0] rom_addr,
  output logic [crbc_pkg::RAM_AW-1:0]  ram_addr
);
  import crbc_pkg::*;

  localparam int unsigned ROM_AW = $clog2(ROM_BYTES);

  logic [3:0]        rom_size_r;
  logic [2:0]        ram_size_r;
  logic              ram_on_r,  ram_on_nxt;
  logic [BANK_W-1:0] bank_r,    bank_nxt;

  logic              ram_present;
  logic              in_rom0, in_romx, in_ram, in_ctl_en, in_ctl_bank;
  logic [BANK_W-1:0] bank_sel;
  logic [18:0]       rd_full;
  logic              load_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_size_r <= '0;
      ram_size_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROM_SIZE: rom_size_r <= cfg_data;
        REG_RAM_SIZE: ram_size_r <= cfg_data[2:0];
        default:      ;
      endcase
    end
  end

  assign ram_present = (ram_size_r >= 3'd2);

  assign in_rom0     = (bus_address[15:14] == 2'b00);
  assign in_romx     = (bus_address[15:14] == 2'b01);
  assign in_ram      = (bus_address[15:13] == 3'b101);
  assign in_ctl_en   = (bus_address[15:13] == 3'b000);
  assign in_ctl_bank = (bus_address[15:13] == 3'b001);

  // 0 becomes 1 before masking, so a masked 0 maps bank 0
  assign bank_sel = (data_in[4:0] == 5'd0) ? 5'd1 : data_in[4:0];

  assign rd_full = in_romx ? {bank_r, bus_address[BANK_OFS_W-1:0]}
                           : {{BANK_W{1'b0}}, bus_address[BANK_OFS_W-1:0]};
  assign load_ok = ({13'd0, rom_index} < 32'(ROM_BYTES));

  assign ram_addr = bus_address[RAM_AW-1:0];

  always_comb begin
    req        = '0;
    req.rd_src = SRC_OPEN;
    rom_addr   = rd_full[ROM_AW-1:0];
    ram_on_nxt = ram_on_r;
    bank_nxt   = bank_r;
    if (accept) begin
      case (op_t'(operation))
        OP_READ: begin
          req.rd_valid = 1'b1;
          if (in_rom0 || in_romx) begin
            req.rom_en = 1'b1;
            req.rd_src = SRC_ROM;
          end else if (in_ram && ram_on_r && ram_present) begin
            req.ram_en = 1'b1;
            req.rd_src = SRC_RAM;
          end
        end
        OP_WRITE: begin
          if (in_ctl_en) begin
            ram_on_nxt = (data_in[3:0] == RAM_ON_KEY);
          end else if (in_ctl_bank) begin
            bank_nxt = bank_sel & bank_mask(rom_size_r);
          end else if (in_ram && ram_on_r && ram_present) begin
            req.ram_en = 1'b1;
            req.ram_we = 1'b1;
          end
        end
        OP_LOAD: begin
          rom_addr   = rom_index[ROM_AW-1:0];
          req.rom_en = load_ok;
          req.rom_we = load_ok;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_on_r <= 1'b1;
      bank_r   <= 5'd1;
    end else begin
      ram_on_r <= ram_on_nxt;
      bank_r   <= bank_nxt;
    end
  end

endmodule

[rtl/cartridge_rom_bank_controller_unit.sv]
// Cartridge ROM bank controller. Each input transfer is a bus read, a bus
// write or a ROM image load (in_tuser selects which); only a bus read gives
// an output transfer. One item is taken per cycle while in_tready is high; a
// read's byte passes through the ROM or RAM read port, which captures it at
// the transfer edge, and then the output register, which takes it when the
// output is free. A stalled output backs up through the output register and
// the read stage before in_tready drops.
// ROM and RAM are each a single-port synchronous memory; a write lands at its
// transfer edge, so a later read always sees it. After reset the RAM is
// zeroed by a clearing pass over all RAM_BYTES (8192) addresses, during
// which in_tready stays low; configuration writes are taken at any time.
// ROM_BYTES must be a power of two; bank addresses wrap modulo its size.
module cartridge_rom_bank_controller_unit #(
  parameter int unsigned ROM_BYTES = 524288
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,   // 0 rom_size_code, 1 ram_size_code
  input  logic [3:0]  cfg_data,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,    // [15:0] bus_address, [34:16] rom_index,
                                   // [42:35] data_in, [47:43] zero
  input  logic [1:0]  in_tuser,    // [1:0] operation
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata    // [7:0] read_data
);
  import crbc_pkg::*;

  localparam int unsigned ROM_AW = $clog2(ROM_BYTES);

  logic                accept;
  mem_req_t            req;
  logic [ROM_AW-1:0]   rom_addr;
  logic [RAM_AW-1:0]   ram_addr_dec;
  logic [7:0]          rom_q, ram_q;

  // clear sweep
  logic [RAM_AW:0]     clr_cnt_r, clr_cnt_nxt;
  logic                clearing;

  logic                ram_en, ram_we;
  logic [RAM_AW-1:0]   ram_addr;
  logic [7:0]          ram_wdata;

  // read stage (memory output) and output register
  logic                s1_valid_r, s1_valid_nxt;
  rd_src_t             s1_src_r, s1_src_nxt;
  logic                s1_adv;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_data_r, out_data_nxt;
  logic [7:0]          rd_byte;

  assign cfg_ready = 1'b1;

  assign clearing  = !clr_cnt_r[RAM_AW];
  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !clearing && (!s1_valid_r || s1_adv);
  assign accept    = in_tvalid && in_tready;

  crbc_decode #(
    .ROM_BYTES (ROM_BYTES)
  ) u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .operation   (in_tuser),
    .bus_address (in_tdata[15:0]),
    .rom_index   (in_tdata[34:16]),
    .data_in     (in_tdata[42:35]),
    .req         (req),
    .rom_addr    (rom_addr),
    .ram_addr    (ram_addr_dec)
  );

  crbc_ram #(
    .WIDTH (8),
    .DEPTH (ROM_BYTES)
  ) u_rom (
    .clk   (clk),
    .en    (req.rom_en),
    .we    (req.rom_we),
    .addr  (rom_addr),
    .wdata (in_tdata[42:35]),
    .rdata (rom_q)
  );

  // the sweep owns the RAM port until it finishes; no item is taken then
  always_comb begin
    if (clearing) begin
      ram_en    = 1'b1;
      ram_we    = 1'b1;
      ram_addr  = clr_cnt_r[RAM_AW-1:0];
      ram_wdata = 8'd0;
    end else begin
      ram_en    = req.ram_en;
      ram_we    = req.ram_we;
      ram_addr  = ram_addr_dec;
      ram_wdata = in_tdata[42:35];
    end
  end

  crbc_ram #(
    .WIDTH (8),
    .DEPTH (RAM_BYTES)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_q)
  );

  assign clr_cnt_nxt = clearing ? clr_cnt_r + 1'b1 : clr_cnt_r;

  always_comb begin
    case (s1_src_r)
      SRC_ROM: rd_byte = rom_q;
      SRC_RAM: rd_byte = ram_q;
      default: rd_byte = OPEN_BUS;
    endcase
  end

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_src_nxt    = s1_src_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (s1_adv) begin
      out_valid_nxt = s1_valid_r;
      out_data_nxt  = rd_byte;
      s1_valid_nxt  = 1'b0;
    end
    // a transfer implies the read stage is empty or moving on
    if (accept) begin
      s1_valid_nxt = req.rd_valid;
      s1_src_nxt   = req.rd_src;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clr_cnt_r   <= clr_cnt_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_src_r   <= s1_src_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
